/* sv/scaled_euclidean_norm_top_assert.svh */
// assertion macros for the scaled euclidean norm block
`ifndef SCALED_EUCLIDEAN_NORM_TOP_ASSERT_SVH
`define SCALED_EUCLIDEAN_NORM_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SEN_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define SEN_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* sv/sen_pkg.sv */
`timescale 1ns / 1ps

package sen_pkg;

  // field and state widths
  localparam int SAMPLE_W = 32;
  localparam int MAG_W    = 31;
  localparam int FRAC_W   = 32;
  localparam int SSQ_W    = 49;
  localparam int Q_W      = 33;
  localparam int NORM_W   = 55;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 56;

  // restoring divider, one quotient bit per cycle
  localparam int DIV_STEPS = 33;
  localparam int CNT_W     = 6;

  // digit by digit square root
  localparam int ROOT_W  = 25;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int SQREM_W = ROOT_W + 1;

  // digit serial multiplier
  localparam int MUL_A_W    = 49;
  localparam int DIGIT_W    = 4;
  localparam int MUL_DIGITS = 9;
  localparam int MUL_B_W    = DIGIT_W * MUL_DIGITS;
  localparam int MUL_CNT_W  = 4;
  localparam int ACC_W      = MUL_A_W + MUL_B_W;

  localparam logic [SSQ_W-1:0]  SSQ_ONE  = SSQ_W'(64'h1_0000_0000);
  localparam logic [SSQ_W-1:0]  SSQ_MAX  = {SSQ_W{1'b1}};
  localparam logic [MAG_W-1:0]  MAG_MAX  = {MAG_W{1'b1}};
  localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_SQ_GO,
    S_SQ_WAIT,
    S_SS_GO,
    S_SS_WAIT,
    S_SQ_INIT,
    S_SQRT,
    S_NM_GO,
    S_NM_WAIT,
    S_FIN
  } state_t;

  // multiply request from the sequencer
  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

/* sv/sen_digit_mul.sv */
`timescale 1ns / 1ps

module sen_digit_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  sen_pkg::mul_req_t         req,
  output logic                      done,
  output logic [sen_pkg::ACC_W-1:0] prod
);

  logic [sen_pkg::MUL_A_W-1:0]   a_reg;
  logic [sen_pkg::MUL_B_W-1:0]   b_reg;
  logic [sen_pkg::ACC_W-1:0]     acc;
  logic [sen_pkg::MUL_CNT_W-1:0] cnt;
  logic                          busy;
  logic [sen_pkg::MUL_A_W+sen_pkg::DIGIT_W-1:0] partial;
  logic [sen_pkg::ACC_W-1:0]     acc_next;

  // one multiplier digit per cycle, most significant first
  assign partial  = a_reg * b_reg[sen_pkg::MUL_B_W-1 -: sen_pkg::DIGIT_W];
  assign acc_next = {acc[sen_pkg::ACC_W-sen_pkg::DIGIT_W-1:0], {sen_pkg::DIGIT_W{1'b0}}}
                    + sen_pkg::ACC_W'(partial);
  assign prod     = acc;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == sen_pkg::MUL_CNT_W'(sen_pkg::MUL_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= req.a;
      b_reg <= req.b;
      acc   <= '0;
    end else if (busy) begin
      b_reg <= {b_reg[sen_pkg::MUL_B_W-sen_pkg::DIGIT_W-1:0], {sen_pkg::DIGIT_W{1'b0}}};
      acc   <= acc_next;
    end
  end

endmodule

/* sv/scaled_euclidean_norm_top.sv */
`timescale 1ns / 1ps

// Streaming Euclidean norm with running scale. Each signed sample updates the
// largest magnitude seen and a fixed point sum of squares scaled by it (17
// integer, 32 fraction bits, saturating); the request marked last returns
// scale*sqrt(ssq) with 16 fraction bits and clears the state. A zero sample
// skips the divider. A nonzero sample goes through the 33-step restoring
// divider (one quotient bit per cycle), which dominates, followed by one pass
// through a 4-bit-per-cycle serial multiplier when it does not exceed the
// current scale and two when it does. The last sample adds a 25-step square
// root and the final multiply. Samples are accepted one at a time; a finished
// norm waits in the output register while the next vector streams in.
module scaled_euclidean_norm_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sen_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] sample
  input  logic                         s_tlast,   // last
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [sen_pkg::M_DATA_W-1:0] m_tdata    // [54:0] norm, [55] zero
);

  sen_pkg::state_t state, state_next;

  logic [sen_pkg::MAG_W-1:0]   scale;
  logic [sen_pkg::SSQ_W-1:0]   ssq;
  logic [sen_pkg::MAG_W-1:0]   mag_reg;
  logic                        last_reg;
  logic                        grow;
  logic [sen_pkg::MAG_W:0]     div_rem;
  logic [sen_pkg::MAG_W-1:0]   div_den;
  logic [sen_pkg::Q_W-1:0]     quo;
  logic [sen_pkg::CNT_W-1:0]   cnt;
  logic [sen_pkg::RAD_W-1:0]   sq_rad;
  logic [sen_pkg::SQREM_W-1:0] sq_rem;
  logic [sen_pkg::ROOT_W-1:0]  sq_root;
  logic [sen_pkg::NORM_W-1:0]  norm;

  logic                        accept;
  logic [sen_pkg::SAMPLE_W-1:0] neg;
  logic [sen_pkg::MAG_W-1:0]   mag;
  logic                        div_ge;
  logic [sen_pkg::MAG_W:0]     div_diff;
  logic [sen_pkg::MAG_W:0]     div_keep;
  logic                        div_end;
  logic [sen_pkg::SQREM_W+1:0] sq_sh;
  logic [sen_pkg::SQREM_W+1:0] sq_trial;
  logic                        sq_ge;
  logic [sen_pkg::SQREM_W+1:0] sq_diff;
  logic                        sqrt_end;
  logic [sen_pkg::Q_W-1:0]     q_new;
  logic [sen_pkg::SSQ_W:0]     add_sum;
  logic [sen_pkg::SSQ_W:0]     grow_sum;
  logic                        out_free;
  logic [sen_pkg::NORM_W-1:0]  norm_sat;

  sen_pkg::mul_req_t           mul_req;
  logic                        mul_done;
  logic [sen_pkg::ACC_W-1:0]   mul_prod;

  sen_digit_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  // sample magnitude, most negative value saturates
  assign neg = -s_tdata;
  always_comb begin
    if (!s_tdata[sen_pkg::SAMPLE_W-1]) begin
      mag = s_tdata[sen_pkg::MAG_W-1:0];
    end else if (neg[sen_pkg::SAMPLE_W-1]) begin
      mag = sen_pkg::MAG_MAX;
    end else begin
      mag = neg[sen_pkg::MAG_W-1:0];
    end
  end

  assign accept = s_tvalid && s_tready;

  // restoring divider step
  assign div_diff = div_rem - {1'b0, div_den};
  assign div_ge   = (div_rem >= {1'b0, div_den});
  assign div_keep = div_ge ? div_diff : div_rem;
  assign div_end  = (cnt == sen_pkg::CNT_W'(sen_pkg::DIV_STEPS - 1));

  // square root step, two radicand bits per cycle
  assign sq_sh    = {sq_rem, sq_rad[sen_pkg::RAD_W-1 -: 2]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);
  assign sq_diff  = sq_sh - sq_trial;
  assign sqrt_end = (cnt == sen_pkg::CNT_W'(sen_pkg::ROOT_W - 1));

  // ssq updates with saturation
  assign q_new    = mul_prod[sen_pkg::FRAC_W +: sen_pkg::Q_W];
  assign add_sum  = {1'b0, ssq} + (sen_pkg::SSQ_W + 1)'(q_new);
  assign grow_sum = {1'b0, mul_prod[sen_pkg::FRAC_W +: sen_pkg::SSQ_W]}
                    + {1'b0, sen_pkg::SSQ_ONE};

  // final product clipped to the norm width
  assign norm_sat = (mul_prod[sen_pkg::ACC_W-1:sen_pkg::NORM_W] != '0)
                    ? sen_pkg::NORM_MAX : mul_prod[sen_pkg::NORM_W-1:0];

  assign out_free = !m_tvalid || m_tready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sen_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer outputs
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mul_req    = '0;
    case (state)
      sen_pkg::S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) begin
          if (mag != '0) begin
            state_next = sen_pkg::S_DIV;
          end else if (s_tlast) begin
            state_next = sen_pkg::S_SQ_INIT;
          end
        end
      end
      sen_pkg::S_DIV: begin
        if (div_end) begin
          state_next = sen_pkg::S_SQ_GO;
        end
      end
      sen_pkg::S_SQ_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = sen_pkg::MUL_A_W'(quo);
        mul_req.b     = sen_pkg::MUL_B_W'(quo);
        state_next    = sen_pkg::S_SQ_WAIT;
      end
      sen_pkg::S_SQ_WAIT: begin
        if (mul_done) begin
          if (grow) begin
            state_next = sen_pkg::S_SS_GO;
          end else if (last_reg) begin
            state_next = sen_pkg::S_SQ_INIT;
          end else begin
            state_next = sen_pkg::S_IDLE;
          end
        end
      end
      sen_pkg::S_SS_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = ssq;
        mul_req.b     = sen_pkg::MUL_B_W'(quo);
        state_next    = sen_pkg::S_SS_WAIT;
      end
      sen_pkg::S_SS_WAIT: begin
        if (mul_done) begin
          state_next = last_reg ? sen_pkg::S_SQ_INIT : sen_pkg::S_IDLE;
        end
      end
      sen_pkg::S_SQ_INIT: begin
        state_next = sen_pkg::S_SQRT;
      end
      sen_pkg::S_SQRT: begin
        if (sqrt_end) begin
          state_next = sen_pkg::S_NM_GO;
        end
      end
      sen_pkg::S_NM_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = sen_pkg::MUL_A_W'(scale);
        mul_req.b     = sen_pkg::MUL_B_W'(sq_root);
        state_next    = sen_pkg::S_NM_WAIT;
      end
      sen_pkg::S_NM_WAIT: begin
        if (mul_done) begin
          state_next = sen_pkg::S_FIN;
        end
      end
      sen_pkg::S_FIN: begin
        if (out_free) begin
          state_next = sen_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sen_pkg::S_IDLE;
      end
    endcase
  end

  // running scale and sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= '0;
      ssq   <= sen_pkg::SSQ_ONE;
    end else begin
      case (state)
        sen_pkg::S_SQ_WAIT: begin
          if (mul_done && !grow) begin
            ssq <= add_sum[sen_pkg::SSQ_W] ? sen_pkg::SSQ_MAX : add_sum[sen_pkg::SSQ_W-1:0];
          end
        end
        sen_pkg::S_SS_WAIT: begin
          if (mul_done) begin
            ssq   <= grow_sum[sen_pkg::SSQ_W] ? sen_pkg::SSQ_MAX
                                               : grow_sum[sen_pkg::SSQ_W-1:0];
            scale <= mag_reg;
          end
        end
        sen_pkg::S_FIN: begin
          if (out_free) begin
            scale <= '0;
            ssq   <= sen_pkg::SSQ_ONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // divider, square root and working registers
  always_ff @(posedge clk) begin
    case (state)
      sen_pkg::S_IDLE: begin
        if (accept) begin
          mag_reg  <= mag;
          last_reg <= s_tlast;
          grow     <= (scale < mag);
          quo      <= '0;
          cnt      <= '0;
          if (scale < mag) begin
            div_rem <= {1'b0, scale};
            div_den <= mag;
          end else begin
            div_rem <= {1'b0, mag};
            div_den <= scale;
          end
        end
      end
      sen_pkg::S_DIV: begin
        div_rem <= {div_keep[sen_pkg::MAG_W-1:0], 1'b0};
        quo     <= {quo[sen_pkg::Q_W-2:0], div_ge};
        cnt     <= cnt + 1'b1;
      end
      sen_pkg::S_SQ_WAIT: begin
        if (mul_done) begin
          quo <= q_new;
        end
      end
      sen_pkg::S_SQ_INIT: begin
        sq_rad  <= sen_pkg::RAD_W'(ssq);
        sq_rem  <= '0;
        sq_root <= '0;
        cnt     <= '0;
      end
      sen_pkg::S_SQRT: begin
        sq_rad  <= {sq_rad[sen_pkg::RAD_W-3:0], 2'b00};
        sq_rem  <= sq_ge ? sq_diff[sen_pkg::SQREM_W-1:0] : sq_sh[sen_pkg::SQREM_W-1:0];
        sq_root <= {sq_root[sen_pkg::ROOT_W-2:0], sq_ge};
        cnt     <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == sen_pkg::S_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sen_pkg::S_FIN && out_free) begin
      norm <= norm_sat;
    end
  end

  assign m_tdata = sen_pkg::M_DATA_W'(norm);

endmodule

/* sv/sen_checker.sv */
`timescale 1ns / 1ps

`include "scaled_euclidean_norm_top_assert.svh"

module sen_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [sen_pkg::S_DATA_W-1:0] s_tdata,
  input logic                         s_tlast,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [sen_pkg::M_DATA_W-1:0] m_tdata
);

  // a held result keeps its value
  `SEN_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "norm changed while stalled")

  // the last request of a vector always starts the root and final multiply
  `SEN_ASSERT_NEXT(a_last_busy, s_tvalid && s_tready && s_tlast, !s_tready, "ready after last request")

  // a nonzero sample always goes through the divider
  `SEN_ASSERT_NEXT(a_nonzero_busy, s_tvalid && s_tready && (s_tdata != '0), !s_tready, "ready after nonzero request")

  // a new result only appears at the end of a busy stretch
  `SEN_ASSERT_NOW(a_out_from_busy, $rose(m_tvalid), $past(!s_tready), "result without finishing sequence")

endmodule

bind scaled_euclidean_norm_top sen_checker u_sen_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
